FILE: src/gmdfs_pkg.sv
// ----------------------------------------------------------------------------
// gmdfs_pkg
// Shared constants, codes and types of the grid maze depth-first path solver.
// ----------------------------------------------------------------------------
package gmdfs_pkg;

    localparam int MAX_SIDE = 32;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int CELL_W   = 2 * SIDE_W;
    localparam int CELLS    = 1 << CELL_W;
    localparam int LEN_W    = CELL_W + 1;
    localparam int N_W      = SIDE_W + 1;
    localparam int GRID_W   = 6;

    // Command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Cell codes
    localparam logic [1:0] CELL_OPEN  = 2'd0;
    localparam logic [1:0] CELL_WALL  = 2'd1;
    localparam logic [1:0] CELL_START = 2'd2;
    localparam logic [1:0] CELL_DEST  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_NO_START = 2'd2;
    localparam logic [1:0] ST_UNREACH  = 2'd3;

    // Neighbour directions, in push order
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Configuration register byte address bit that selects beyond register 0
    localparam int REG_SEL_BIT = 2;
    localparam int PADDR_W     = 3;

    typedef struct packed {
        logic [1:0]        command;
        logic [SIDE_W-1:0] cell_x;
        logic [SIDE_W-1:0] cell_y;
        logic [1:0]        cell_code;
        logic [CELL_W-1:0] path_index;
    } t_cmd;

    typedef struct packed {
        logic              done;
        logic [1:0]        status;
        logic [SIDE_W-1:0] step_x;
        logic [SIDE_W-1:0] step_y;
        logic [LEN_W-1:0]  path_length;
        logic              index_valid;
    } t_result;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_RD_WAIT  = 12'b0000_0000_0010,
        S_SCAN     = 12'b0000_0000_0100,
        S_SEED     = 12'b0000_0000_1000,
        S_POP      = 12'b0000_0001_0000,
        S_POP_WAIT = 12'b0000_0010_0000,
        S_TRUNC    = 12'b0000_0100_0000,
        S_NEIGH    = 12'b0000_1000_0000,
        S_NCHK     = 12'b0001_0000_0000,
        S_DST_RD   = 12'b0010_0000_0000,
        S_DST_CHK  = 12'b0100_0000_0000,
        S_COMPACT  = 12'b1000_0000_0000
    } t_state;

endpackage

FILE: src/grid_maze_dfs_path_solver.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_solver
// Square maze store with a depth-first path search and indexed path read-back.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Beat contents
//  command   in         start high, busy low         command, cell, code, index
//  result    out        o_done, one cycle, no stall  status, step, length, valid
//  config    in         APB write, pready tied high  grid_size at byte 0
//
//  A cell write or an unused command strobes its result on the next cycle,
//  and a new beat may enter at once. A path read goes through one registered
//  read of the path memory. A solve sweeps the whole cell memory, seeds the
//  search, then for each expanded cell pops the stack, drops finished chain
//  entries, checks the four neighbours and the cell's own code, and ends with
//  a compaction pass over the chain.
//  Reset is synchronous; the result port cannot be stalled.
module grid_maze_dfs_path_solver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [4:0]                    i_cell_x,
    input  logic [4:0]                    i_cell_y,
    input  logic [1:0]                    i_cell_code,
    input  logic [9:0]                    i_path_index,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [4:0]                    o_step_x,
    output logic [4:0]                    o_step_y,
    output logic [10:0]                   o_path_length,
    output logic                          o_index_valid,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmdfs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [gmdfs_pkg::GRID_W-1:0] r_grid_size;
    gmdfs_pkg::t_cmd    cmd;
    gmdfs_pkg::t_result res;
    logic               reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = !paddr[gmdfs_pkg::REG_SEL_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= gmdfs_pkg::GRID_W'(32);
        end else if (psel && penable && pwrite && reg_hit) begin
            r_grid_size <= pwdata[gmdfs_pkg::GRID_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(32 - gmdfs_pkg::GRID_W){1'b0}}, r_grid_size} : '0;

    assign cmd.command    = i_command;
    assign cmd.cell_x     = i_cell_x;
    assign cmd.cell_y     = i_cell_y;
    assign cmd.cell_code  = i_cell_code;
    assign cmd.path_index = i_path_index;

    gmdfs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (cmd),
        .i_grid_size (r_grid_size),
        .o_busy      (busy),
        .o_result    (res)
    );

    assign o_done        = res.done;
    assign o_status      = res.status;
    assign o_step_x      = res.step_x;
    assign o_step_y      = res.step_y;
    assign o_path_length = res.path_length;
    assign o_index_valid = res.index_valid;

endmodule

FILE: src/gmdfs_ram.sv
// ----------------------------------------------------------------------------
// gmdfs_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gmdfs_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

FILE: src/gmdfs_core.sv
// ----------------------------------------------------------------------------
// gmdfs_core
// Command sequencer around the cell, visited, stack and path memories.
// ----------------------------------------------------------------------------
module gmdfs_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  gmdfs_pkg::t_cmd              i_cmd,
    input  logic [gmdfs_pkg::GRID_W-1:0] i_grid_size,
    output logic                         o_busy,
    output gmdfs_pkg::t_result           o_result
);

    localparam int CW = gmdfs_pkg::CELL_W;
    localparam int SW = gmdfs_pkg::SIDE_W;
    localparam int LW = gmdfs_pkg::LEN_W;

    gmdfs_pkg::t_state  r_state, n_state;
    gmdfs_pkg::t_result r_res, n_res;
    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_sp, n_sp;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_w, n_w;
    logic [CW-1:0] r_p, n_p;
    logic [CW-1:0] r_t, n_t;
    logic [CW-1:0] r_start_cell, n_start_cell;
    logic [1:0]    r_dir, n_dir;
    logic          r_have, n_have;
    logic          r_reached, n_reached;
    logic          r_pidx_ok, n_pidx_ok;
    logic [LW-1:0] r_stored_len, n_stored_len;
    logic [1:0]    r_outcome, n_outcome;

    // Memory ports
    logic          cell_we, vis_we, stk_we, path_we;
    logic [CW-1:0] cell_waddr, cell_raddr, vis_waddr, vis_raddr;
    logic [CW-1:0] stk_waddr, stk_raddr, path_waddr, path_raddr;
    logic [1:0]    cell_wdata, cell_rdata;
    logic          vis_wdata, vis_rdata;
    logic [CW-1:0] stk_wdata, stk_rdata;
    logic [CW:0]   path_wdata, path_rdata;

    logic [gmdfs_pkg::N_W-1:0] side_n;
    logic [SW-1:0] px, py, tx, ty, sx, sy;
    logic          nb_ok;
    logic [CW-1:0] scan_addr;

    gmdfs_ram #(.WIDTH(2), .ADDR_W(CW)) u_cell_ram (
        .i_clk(i_clk), .i_we(cell_we), .i_waddr(cell_waddr), .i_wdata(cell_wdata),
        .i_raddr(cell_raddr), .o_rdata(cell_rdata)
    );
    gmdfs_ram #(.WIDTH(1), .ADDR_W(CW)) u_vis_ram (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_raddr(vis_raddr), .o_rdata(vis_rdata)
    );
    gmdfs_ram #(.WIDTH(CW), .ADDR_W(CW)) u_stk_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );
    // Path entries carry an expanded flag above the cell number.
    gmdfs_ram #(.WIDTH(CW + 1), .ADDR_W(CW)) u_path_ram (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_waddr), .i_wdata(path_wdata),
        .i_raddr(path_raddr), .o_rdata(path_rdata)
    );

    always_comb begin
        if (int'(i_grid_size) > gmdfs_pkg::MAX_SIDE) begin
            side_n = gmdfs_pkg::N_W'(gmdfs_pkg::MAX_SIDE);
        end else begin
            side_n = gmdfs_pkg::N_W'(i_grid_size);
        end
    end

    assign px = r_p[SW-1:0];
    assign py = r_p[CW-1:SW];
    assign scan_addr = r_idx[CW-1:0] - CW'(1);
    assign sx = scan_addr[SW-1:0];
    assign sy = scan_addr[CW-1:SW];

    always_comb begin
        tx    = px;
        ty    = py;
        nb_ok = 1'b0;
        unique case (r_dir)
            gmdfs_pkg::DIR_LEFT: begin
                tx    = px - SW'(1);
                nb_ok = (px != '0);
            end
            gmdfs_pkg::DIR_RIGHT: begin
                tx    = px + SW'(1);
                nb_ok = (({1'b0, px} + gmdfs_pkg::N_W'(1)) < side_n);
            end
            gmdfs_pkg::DIR_UP: begin
                ty    = py - SW'(1);
                nb_ok = (py != '0);
            end
            gmdfs_pkg::DIR_DOWN: begin
                ty    = py + SW'(1);
                nb_ok = (({1'b0, py} + gmdfs_pkg::N_W'(1)) < side_n);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_res.done   = 1'b0;
        n_idx        = r_idx;
        n_sp         = r_sp;
        n_len        = r_len;
        n_w          = r_w;
        n_p          = r_p;
        n_t          = r_t;
        n_start_cell = r_start_cell;
        n_dir        = r_dir;
        n_have       = r_have;
        n_reached    = r_reached;
        n_pidx_ok    = r_pidx_ok;
        n_stored_len = r_stored_len;
        n_outcome    = r_outcome;

        cell_we    = 1'b0;
        cell_waddr = {i_cmd.cell_y, i_cmd.cell_x};
        cell_wdata = i_cmd.cell_code;
        cell_raddr = r_idx[CW-1:0];
        vis_we     = 1'b0;
        vis_waddr  = r_idx[CW-1:0];
        vis_wdata  = 1'b0;
        vis_raddr  = {ty, tx};
        stk_we     = 1'b0;
        stk_waddr  = r_sp[CW-1:0];
        stk_wdata  = r_t;
        stk_raddr  = r_sp[CW-1:0] - CW'(1);
        path_we    = 1'b0;
        path_waddr = r_len[CW-1:0];
        path_wdata = {1'b0, r_t};
        path_raddr = r_len[CW-1:0] - CW'(1);

        unique case (r_state)
            gmdfs_pkg::S_IDLE: begin
                path_raddr = i_cmd.path_index;
                if (i_start) begin
                    unique case (i_cmd.command)
                        gmdfs_pkg::CMD_WRITE: begin
                            if (int'(i_cmd.cell_x) < gmdfs_pkg::MAX_SIDE &&
                                int'(i_cmd.cell_y) < gmdfs_pkg::MAX_SIDE) begin
                                cell_we = 1'b1;
                            end
                            n_res = '{done: 1'b1, status: gmdfs_pkg::ST_ACCEPTED,
                                      step_x: '0, step_y: '0,
                                      path_length: r_stored_len, index_valid: 1'b0};
                        end
                        gmdfs_pkg::CMD_SOLVE: begin
                            n_idx   = '0;
                            n_have  = 1'b0;
                            n_state = gmdfs_pkg::S_SCAN;
                        end
                        gmdfs_pkg::CMD_READ: begin
                            n_pidx_ok = ({1'b0, i_cmd.path_index} < r_stored_len);
                            n_state   = gmdfs_pkg::S_RD_WAIT;
                        end
                        default: begin
                            n_res = '{done: 1'b1, status: gmdfs_pkg::ST_ACCEPTED,
                                      step_x: '0, step_y: '0,
                                      path_length: r_stored_len, index_valid: 1'b0};
                        end
                    endcase
                end
            end

            gmdfs_pkg::S_RD_WAIT: begin
                n_res.done        = 1'b1;
                n_res.status      = r_outcome;
                n_res.path_length = r_stored_len;
                n_res.index_valid = r_pidx_ok;
                n_res.step_x      = r_pidx_ok ? path_rdata[SW-1:0] : '0;
                n_res.step_y      = r_pidx_ok ? path_rdata[CW-1:SW] : '0;
                n_state           = gmdfs_pkg::S_IDLE;
            end

            // Clear the visited marks and look for the last start cell.
            gmdfs_pkg::S_SCAN: begin
                if (r_idx != LW'(gmdfs_pkg::CELLS)) begin
                    vis_we = 1'b1;
                end
                if (r_idx != '0 && cell_rdata == gmdfs_pkg::CELL_START &&
                    {1'b0, sx} < side_n && {1'b0, sy} < side_n) begin
                    n_have       = 1'b1;
                    n_start_cell = scan_addr;
                end
                if (r_idx == LW'(gmdfs_pkg::CELLS)) begin
                    if (n_have) begin
                        n_state = gmdfs_pkg::S_SEED;
                    end else begin
                        n_stored_len = '0;
                        n_outcome    = gmdfs_pkg::ST_NO_START;
                        n_res = '{done: 1'b1, status: gmdfs_pkg::ST_NO_START,
                                  step_x: '0, step_y: '0,
                                  path_length: '0, index_valid: 1'b0};
                        n_state = gmdfs_pkg::S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end

            gmdfs_pkg::S_SEED: begin
                vis_we     = 1'b1;
                vis_waddr  = r_start_cell;
                vis_wdata  = 1'b1;
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = r_start_cell;
                path_we    = 1'b1;
                path_waddr = '0;
                path_wdata = {1'b0, r_start_cell};
                n_sp       = LW'(1);
                n_len      = LW'(1);
                n_reached  = 1'b0;
                n_state    = gmdfs_pkg::S_POP;
            end

            gmdfs_pkg::S_POP: begin
                if (r_sp == '0) begin
                    n_idx   = '0;
                    n_w     = '0;
                    n_state = gmdfs_pkg::S_COMPACT;
                end else begin
                    n_sp    = r_sp - LW'(1);
                    n_state = gmdfs_pkg::S_POP_WAIT;
                end
            end

            gmdfs_pkg::S_POP_WAIT: begin
                n_p   = stk_rdata;
                n_dir = gmdfs_pkg::DIR_LEFT;
                if (r_len == '0) begin
                    n_state = gmdfs_pkg::S_NEIGH;
                end else begin
                    n_state = gmdfs_pkg::S_TRUNC;
                end
            end

            // Drop finished branches until the chain ends at the popped cell.
            gmdfs_pkg::S_TRUNC: begin
                n_dir = gmdfs_pkg::DIR_LEFT;
                if (path_rdata[CW-1:0] == r_p) begin
                    path_we    = 1'b1;
                    path_waddr = r_len[CW-1:0] - CW'(1);
                    path_wdata = {1'b1, r_p};
                    n_state    = gmdfs_pkg::S_NEIGH;
                end else begin
                    n_len      = r_len - LW'(1);
                    path_raddr = r_len[CW-1:0] - CW'(2);
                    if (r_len == LW'(1)) begin
                        n_state = gmdfs_pkg::S_NEIGH;
                    end
                end
            end

            gmdfs_pkg::S_NEIGH: begin
                cell_raddr = {ty, tx};
                n_t        = {ty, tx};
                if (nb_ok) begin
                    n_state = gmdfs_pkg::S_NCHK;
                end else if (r_dir == gmdfs_pkg::DIR_DOWN) begin
                    n_state = gmdfs_pkg::S_DST_RD;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end

            gmdfs_pkg::S_NCHK: begin
                if (cell_rdata != gmdfs_pkg::CELL_WALL && !vis_rdata) begin
                    vis_we    = 1'b1;
                    vis_waddr = r_t;
                    vis_wdata = 1'b1;
                    if (r_sp < LW'(gmdfs_pkg::CELLS)) begin
                        stk_we = 1'b1;
                        n_sp   = r_sp + LW'(1);
                    end
                    if (r_len < LW'(gmdfs_pkg::CELLS)) begin
                        path_we = 1'b1;
                        n_len   = r_len + LW'(1);
                    end
                end
                if (r_dir == gmdfs_pkg::DIR_DOWN) begin
                    n_state = gmdfs_pkg::S_DST_RD;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = gmdfs_pkg::S_NEIGH;
                end
            end

            gmdfs_pkg::S_DST_RD: begin
                cell_raddr = r_p;
                n_state    = gmdfs_pkg::S_DST_CHK;
            end

            gmdfs_pkg::S_DST_CHK: begin
                if (cell_rdata == gmdfs_pkg::CELL_DEST) begin
                    n_reached = 1'b1;
                    n_idx     = '0;
                    n_w       = '0;
                    n_state   = gmdfs_pkg::S_COMPACT;
                end else begin
                    n_state = gmdfs_pkg::S_POP;
                end
            end

            // Keep only expanded entries; cells still pending fall out.
            gmdfs_pkg::S_COMPACT: begin
                path_raddr = r_idx[CW-1:0];
                path_waddr = r_w[CW-1:0];
                path_wdata = path_rdata;
                if (r_idx != '0 && path_rdata[CW]) begin
                    path_we = 1'b1;
                    n_w     = r_w + LW'(1);
                end
                if (r_idx == r_len) begin
                    n_stored_len = n_w;
                    n_outcome    = r_reached ? gmdfs_pkg::ST_FOUND : gmdfs_pkg::ST_UNREACH;
                    n_res.done        = 1'b1;
                    n_res.status      = n_outcome;
                    n_res.step_x      = '0;
                    n_res.step_y      = '0;
                    n_res.path_length = n_w;
                    n_res.index_valid = 1'b0;
                    n_state           = gmdfs_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end

            default: n_state = gmdfs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gmdfs_pkg::S_IDLE;
            r_res        <= '0;
            r_stored_len <= '0;
            r_outcome    <= gmdfs_pkg::ST_ACCEPTED;
        end else begin
            r_state      <= n_state;
            r_res        <= n_res;
            r_stored_len <= n_stored_len;
            r_outcome    <= n_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_sp         <= n_sp;
        r_len        <= n_len;
        r_w          <= n_w;
        r_p          <= n_p;
        r_t          <= n_t;
        r_start_cell <= n_start_cell;
        r_dir        <= n_dir;
        r_have       <= n_have;
        r_reached    <= n_reached;
        r_pidx_ok    <= n_pidx_ok;
    end

    assign o_busy   = (r_state != gmdfs_pkg::S_IDLE);
    assign o_result = r_res;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid maze depth-first path solver. A local
// predictor keeps its own maze, visited map, search stack and path, and
// every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import gmdfs_pkg::*;

    localparam int IDLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]  status;
        logic [4:0]  step_x;
        logic [4:0]  step_y;
        logic [10:0] path_length;
        logic        index_valid;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [4:0]  i_cell_x;
    logic [4:0]  i_cell_y;
    logic [1:0]  i_cell_code;
    logic [9:0]  i_path_index;
    logic        o_done;
    logic [1:0]  o_status;
    logic [4:0]  o_step_x;
    logic [4:0]  o_step_y;
    logic [10:0] o_path_length;
    logic        o_index_valid;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_maze_dfs_path_solver uut (.*);

    // Predictor state
    logic [1:0]  maze_cell [CELLS];
    bit          maze_seen [CELLS];
    int unsigned dfs_stack [CELLS];
    int unsigned trail     [CELLS];
    int unsigned trail_len;
    logic [1:0]  last_status;
    int unsigned cur_grid;

    t_beat pending_results[$];
    int    error_count;
    int    items_sent;
    int    solves_done;
    int    found_count;
    int    idle_cycles;
    bit    gaps_off;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Depth-first search exactly as the block is meant to run it.
    function automatic void solve_maze();
        int unsigned n, sp, len, p, t, w, i, j;
        int tx, ty, d, sx, sy;
        bit have_start, reached;
        n = (cur_grid > MAX_SIDE) ? MAX_SIDE : cur_grid;
        sp = 0;
        len = 0;
        have_start = 0;
        reached = 0;
        p = 0;
        foreach (maze_seen[k]) maze_seen[k] = 0;
        for (int y = 0; y < n; y++) begin
            for (int x = 0; x < n; x++) begin
                if (maze_cell[y * MAX_SIDE + x] == CELL_START) begin
                    p = y * MAX_SIDE + x;
                    have_start = 1;
                end
            end
        end
        if (!have_start) begin
            trail_len = 0;
            last_status = ST_NO_START;
            return;
        end
        dfs_stack[sp++] = p;
        trail[len++] = p;
        maze_seen[p] = 1;
        while (sp > 0) begin
            p = dfs_stack[--sp];
            sx = p % MAX_SIDE;
            sy = p / MAX_SIDE;
            while (len > 0 && trail[len - 1] != p) len--;
            for (d = 0; d < 4; d++) begin
                tx = sx + ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
                ty = sy + ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
                if (tx < 0 || ty < 0 || tx >= int'(n) || ty >= int'(n)) continue;
                t = ty * MAX_SIDE + tx;
                if (maze_cell[t] == CELL_WALL || maze_seen[t]) continue;
                maze_seen[t] = 1;
                if (sp < CELLS) dfs_stack[sp++] = t;
                if (len < CELLS) trail[len++] = t;
            end
            if (maze_cell[p] == CELL_DEST) begin
                reached = 1;
                break;
            end
        end
        // Cells still waiting on the stack are not part of the chain.
        while (sp > 0) begin
            w = dfs_stack[--sp];
            for (i = 0; i < len; i++) begin
                if (trail[i] == w) begin
                    for (j = i; j + 1 < len; j++) trail[j] = trail[j + 1];
                    len--;
                    break;
                end
            end
        end
        trail_len = len;
        last_status = reached ? ST_FOUND : ST_UNREACH;
    endfunction

    function automatic t_beat predict_result(logic [1:0] cmd, logic [4:0] cx,
                                             logic [4:0] cy, logic [1:0] code,
                                             logic [9:0] idx);
        t_beat r;
        r = '{ST_ACCEPTED, 5'd0, 5'd0, 11'd0, 1'b0};
        if (cmd == CMD_WRITE) begin
            maze_cell[cy * MAX_SIDE + cx] = code;
        end else if (cmd == CMD_SOLVE) begin
            solve_maze();
            r.status = last_status;
        end else if (cmd == CMD_READ) begin
            r.status = last_status;
            if (idx < trail_len) begin
                r.step_x = 5'(trail[idx] % MAX_SIDE);
                r.step_y = 5'(trail[idx] / MAX_SIDE);
                r.index_valid = 1'b1;
            end
        end
        r.path_length = 11'(trail_len);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gaps_off || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called just after a falling edge; returns after the beat is taken.
    task automatic send_cmd(logic [1:0] cmd, logic [4:0] cx, logic [4:0] cy,
                            logic [1:0] code, logic [9:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_command = cmd;
        i_cell_x = cx;
        i_cell_y = cy;
        i_cell_code = code;
        i_path_index = idx;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pending_results.insert(pending_results.size(),
                               predict_result(cmd, cx, cy, code, idx));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (pending_results.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_grid(int unsigned val);
        wait_idle();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = '0;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cur_grid = val & 6'h3f;
    endtask

    // Writes an n by n maze. starts/dests say how many of each are placed.
    task automatic build_maze(int n, int wall_pct, int starts, int dests);
        logic [1:0] code;
        int sx[2], sy[2], dx[2], dy[2];
        for (int k = 0; k < 2; k++) begin
            sx[k] = $urandom_range(0, n - 1);
            sy[k] = $urandom_range(0, n - 1);
            dx[k] = $urandom_range(0, n - 1);
            dy[k] = $urandom_range(0, n - 1);
        end
        for (int y = 0; y < n; y++) begin
            for (int x = 0; x < n; x++) begin
                code = ($urandom_range(0, 99) < wall_pct) ? CELL_WALL : CELL_OPEN;
                for (int k = 0; k < dests; k++)
                    if (x == dx[k] && y == dy[k]) code = CELL_DEST;
                for (int k = 0; k < starts; k++)
                    if (x == sx[k] && y == sy[k]) code = CELL_START;
                send_cmd(CMD_WRITE, 5'(x), 5'(y), code, 10'd0);
            end
        end
    endtask

    task automatic solve_and_read(int reads);
        send_cmd(CMD_SOLVE, 5'($urandom), 5'($urandom), 2'($urandom), 10'($urandom));
        solves_done++;
        // The prediction for the solve has just been made, so last_status is its outcome.
        if (last_status == ST_FOUND) found_count++;
        for (int k = 0; k < reads; k++) begin
            if ($urandom_range(0, 3) == 0 || trail_len == 0)
                send_cmd(CMD_READ, 5'($urandom), 5'($urandom), 2'($urandom),
                         10'($urandom_range(0, 1023)));
            else
                send_cmd(CMD_READ, 5'($urandom), 5'($urandom), 2'($urandom),
                         10'($urandom_range(0, trail_len)));
        end
    endtask

    task automatic test_empty_state();
        send_cmd(CMD_READ, 5'd0, 5'd0, CELL_OPEN, 10'd0);
        send_cmd(CMD_READ, 5'd31, 5'd31, CELL_DEST, 10'd1023);
        send_cmd(2'd3, 5'd31, 5'd31, CELL_DEST, 10'h3ff);
        set_grid(0);
        send_cmd(CMD_SOLVE, 5'd0, 5'd0, CELL_OPEN, 10'd0);
        send_cmd(CMD_READ, 5'd0, 5'd0, CELL_OPEN, 10'd0);
    endtask

    task automatic test_full_grid();
        set_grid(32);
        build_maze(32, 20, 1, 1);
        solve_and_read(4);
        send_cmd(CMD_READ, 5'd0, 5'd0, CELL_OPEN, 10'd1023);
        send_cmd(CMD_READ, 5'd0, 5'd0, CELL_OPEN, 10'd0);
        set_grid(63);
        solve_and_read(2);
    endtask

    task automatic test_special_cases();
        set_grid(1);
        send_cmd(CMD_WRITE, 5'd0, 5'd0, CELL_START, 10'd0);
        solve_and_read(2);
        // Two starts: the later one in row-major order wins.
        set_grid(4);
        build_maze(4, 0, 2, 1);
        solve_and_read(3);
        // Destination boxed in by walls.
        send_cmd(CMD_WRITE, 5'd0, 5'd0, CELL_START, 10'd0);
        send_cmd(CMD_WRITE, 5'd3, 5'd3, CELL_DEST, 10'd0);
        send_cmd(CMD_WRITE, 5'd2, 5'd3, CELL_WALL, 10'd0);
        send_cmd(CMD_WRITE, 5'd3, 5'd2, CELL_WALL, 10'd0);
        solve_and_read(3);
        // A write outside the grid in use is kept for a later larger grid.
        send_cmd(CMD_WRITE, 5'd31, 5'd31, CELL_WALL, 10'd0);
    endtask

    task automatic test_random_mazes(int target);
        int n, r;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 3) n = 0;
            else if (r < 6) n = 32;
            else if (r < 8) n = $urandom_range(33, 63);
            else if (r < 12) n = 1;
            else n = $urandom_range(2, 8);
            gaps_off = ($urandom_range(0, 3) == 0);
            set_grid(n);
            if (n > 0 && n <= MAX_SIDE && n < 32) begin
                r = $urandom_range(0, 9);
                build_maze(n, $urandom_range(0, 45), (r == 0) ? 0 : (r == 1) ? 2 : 1,
                           (r == 2) ? 0 : 1);
            end
            if ($urandom_range(0, 4) == 0)
                send_cmd(2'd3, 5'($urandom), 5'($urandom), 2'($urandom), 10'($urandom));
            solve_and_read($urandom_range(2, 8));
        end
    endtask

    always @(posedge i_clk) begin
        t_beat exp_r;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d len %0d", $time,
                         o_status, o_path_length);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status || o_step_x !== exp_r.step_x ||
                    o_step_y !== exp_r.step_y || o_path_length !== exp_r.path_length ||
                    o_index_valid !== exp_r.index_valid) begin
                    $display("%0t: expected st %0d x %0d y %0d len %0d v %0d,",
                             $time, exp_r.status, exp_r.step_x, exp_r.step_y,
                             exp_r.path_length, exp_r.index_valid,
                             " got st %0d x %0d y %0d len %0d v %0d",
                             o_status, o_step_x, o_step_y, o_path_length,
                             o_index_valid);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_WRITE;
        i_cell_x = '0;
        i_cell_y = '0;
        i_cell_code = CELL_OPEN;
        i_path_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_cycles = 0;
        error_count = 0;
        items_sent = 0;
        solves_done = 0;
        found_count = 0;
        gaps_off = 0;
        trail_len = 0;
        last_status = ST_ACCEPTED;
        cur_grid = 32;
        foreach (maze_cell[k]) maze_cell[k] = CELL_OPEN;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_state();
        test_full_grid();
        test_special_cases();
        test_random_mazes(1350);

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("Sent %0d commands including %0d solves (%0d reached the destination)",
                 items_sent, solves_done, found_count);
        $display("Grid sizes covered 0, 1, small, 32 and oversized; %0d errors", error_count);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
